@@ hdl/qmsc_pkg.sv @@
// Shared constants and width helpers for the quad minimum corner sine block.
package qmsc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORNERS = 4;
	localparam int COORDS = 8;

	// Rounds a bit count up to whole bytes.
	function automatic int byte_pad(input int bits);
		byte_pad = ((bits + 7) / 8) * 8;
	endfunction

endpackage

@@ hdl/qmsc_front.sv @@
// Geometry stages: edge differences, products, corner areas and lengths, squared terms.
module qmsc_front import qmsc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int D = COORD_BITS + 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ccw,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_quad,
	input  logic [COORDS-1:0][COORD_BITS-1:0] in_xy,
	input  logic nx_en,
	output logic v_out,
	output logic deg_out,
	output logic [CORNERS-1:0][4*D-1:0] asq_out,
	output logic [CORNERS-1:0][4*D-1:0] prod_out
);

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en4 = !v_s4 || nx_en;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// Stage 1: vertex order and edge differences.
	logic signed [CORNERS-1:0][D-1:0] px, py;
	logic signed [CORNERS-1:0][D-1:0] dx_s1, dy_s1;
	logic quad_s1;

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			int src;
			src = ccw ? i : (CORNERS - 1 - i);
			px[i] = D'(signed'(in_xy[2*src]));
			py[i] = D'(signed'(in_xy[2*src+1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			quad_s1 <= in_quad;
			for (int i = 0; i < CORNERS; i++) begin
				dx_s1[i] <= px[i] - px[(i + 1) % CORNERS];
				dy_s1[i] <= py[i] - py[(i + 1) % CORNERS];
			end
		end
	end

	// Stage 2: the cross and square products.
	logic signed [CORNERS-1:0][2*D-1:0] pa_s2, pb_s2, sx_s2, sy_s2;
	logic quad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			quad_s2 <= quad_s1;
			for (int i = 0; i < CORNERS; i++) begin
				pa_s2[i] <= signed'(dx_s1[(i + 3) % CORNERS]) * signed'(dy_s1[i]);
				pb_s2[i] <= signed'(dx_s1[i]) * signed'(dy_s1[(i + 3) % CORNERS]);
				sx_s2[i] <= signed'(dx_s1[i]) * signed'(dx_s1[i]);
				sy_s2[i] <= signed'(dy_s1[i]) * signed'(dy_s1[i]);
			end
		end
	end

	// Stage 3: areas, squared lengths and the rejection flag.
	logic signed [CORNERS-1:0][2*D:0] area;
	logic [CORNERS-1:0][2*D-1:0] area_s3, len_s3;
	logic deg_s3;
	logic any_bad;

	always_comb begin
		any_bad = 1'b0;
		for (int i = 0; i < CORNERS; i++) begin
			area[i] = (2*D+1)'(signed'(pa_s2[i])) - (2*D+1)'(signed'(pb_s2[i]));
			if (area[i][2*D] || area[i] == '0) begin
				any_bad = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			deg_s3 <= !quad_s2 || any_bad;
			for (int i = 0; i < CORNERS; i++) begin
				area_s3[i] <= area[i][2*D-1:0];
				len_s3[i] <= unsigned'(sx_s2[i]) + unsigned'(sy_s2[i]);
			end
		end
	end

	// Stage 4: area squared and the product of the two adjacent lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	logic deg_s4;
	logic [CORNERS-1:0][4*D-1:0] asq_s4, prod_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			deg_s4 <= deg_s3;
			for (int i = 0; i < CORNERS; i++) begin
				asq_s4[i] <= (4*D)'(area_s3[i]) * (4*D)'(area_s3[i]);
				prod_s4[i] <= (4*D)'(len_s3[(i + 3) % CORNERS]) * (4*D)'(len_s3[i]);
			end
		end
	end

	assign v_out = v_s4;
	assign deg_out = deg_s4;
	assign asq_out = asq_s4;
	assign prod_out = prod_s4;

endmodule

@@ hdl/qmsc_root_stage.sv @@
// One result bit of the corner sine for all four corners, by digit recurrence.
module qmsc_root_stage import qmsc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int BIT = 0,
	localparam int D = COORD_BITS + 1,
	localparam int RW = 4*D + 2*FRAC_BITS,
	localparam int YW = 4*D + FRAC_BITS + 1,
	localparam int QW = FRAC_BITS + 1,
	localparam int TW = RW + 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic deg_in,
	input  logic [CORNERS-1:0][RW-1:0] r_in,
	input  logic [CORNERS-1:0][YW-1:0] y_in,
	input  logic [CORNERS-1:0][4*D-1:0] p_in,
	input  logic [CORNERS-1:0][QW-1:0] q_in,
	input  logic nx_en,
	output logic en,
	output logic v_out,
	output logic deg_out,
	output logic [CORNERS-1:0][RW-1:0] r_out,
	output logic [CORNERS-1:0][YW-1:0] y_out,
	output logic [CORNERS-1:0][4*D-1:0] p_out,
	output logic [CORNERS-1:0][QW-1:0] q_out
);

	// The residual holds A*A*2^(2F) - q*q*P and y holds q*P, so setting this bit
	// costs (y << (BIT+1)) + (P << 2*BIT).
	logic [CORNERS-1:0][TW-1:0] cost;
	logic [CORNERS-1:0] take;
	logic v_q;

	assign en = !v_q || nx_en;

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			cost[i] = (TW'(y_in[i]) << (BIT + 1)) + (TW'(p_in[i]) << (2 * BIT));
			take[i] = TW'(r_in[i]) >= cost[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_out <= deg_in;
			p_out <= p_in;
			for (int i = 0; i < CORNERS; i++) begin
				if (take[i]) begin
					r_out[i] <= RW'(TW'(r_in[i]) - cost[i]);
					y_out[i] <= y_in[i] + (YW'(p_in[i]) << BIT);
					q_out[i] <= q_in[i] | (QW'(1) << BIT);
				end else begin
					r_out[i] <= r_in[i];
					y_out[i] <= y_in[i];
					q_out[i] <= q_in[i];
				end
			end
		end
	end

	assign v_out = v_q;

endmodule

@@ hdl/qmsc_min_out.sv @@
// Minimum over the four corner values and the output register.
module qmsc_min_out import qmsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int QW = FRAC_BITS + 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	input  logic deg_in,
	input  logic [CORNERS-1:0][QW-1:0] q_in,
	output logic en,
	output logic out_valid,
	input  logic out_ready,
	output logic [QW-1:0] min_sine,
	output logic degenerate
);

	logic [QW-1:0] m01, m23, mall;

	assign en = !out_valid || out_ready;
	assign m01 = (q_in[1] < q_in[0]) ? q_in[1] : q_in[0];
	assign m23 = (q_in[3] < q_in[2]) ? q_in[3] : q_in[2];
	assign mall = (m23 < m01) ? m23 : m01;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate <= deg_in;
			min_sine <= deg_in ? '0 : mall;
		end
	end

endmodule

@@ hdl/quad_min_sin_corner.sv @@
// Top level of the quad minimum corner sine block.
// Takes one quadrilateral per beat on the s_axis channel: tdata carries the
// eight vertex coordinates, tuser the is_quad flag. Each cell yields one beat
// on m_axis with the minimum corner sine (unsigned Q1.FRAC_BITS, truncated) in
// tdata and the degenerate flag in tuser.
// cfg_we/cfg_wdata write the vertex order register (1 counter-clockwise, the
// reset value; 0 clockwise). Write it only while the block is empty.
// Pipeline: four geometry stages, one stage per result bit of the square-root
// recurrence, and the output register.
// Throughput is one cell per cycle while the receiver takes results; each stage has its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles are squeezed out.
// When the receiver holds tready low, the output beat holds and the stages fill
// up behind it; s_axis_tready falls only once every stage is occupied.
// Reset empties all stages and sets counter-clockwise order.
module quad_min_sin_corner import qmsc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int D = COORD_BITS + 1,
	localparam int RW = 4*D + 2*FRAC_BITS,
	localparam int YW = 4*D + FRAC_BITS + 1,
	localparam int QW = FRAC_BITS + 1,
	localparam int IW = COORDS * COORD_BITS,
	localparam int OW = byte_pad(QW)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [IW-1:0] s_axis_tdata,   // x0, y0, x1, y1, x2, y2, x3, y3
	input  logic s_axis_tuser,            // is_quad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [OW-1:0] m_axis_tdata,   // min_sine, zero fill
	output logic m_axis_tuser             // degenerate
);

	logic ccw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccw_q <= 1'b1;
		end else if (cfg_we) begin
			ccw_q <= cfg_wdata;
		end
	end

	logic [COORDS-1:0][COORD_BITS-1:0] xy;
	assign xy = s_axis_tdata;

	logic [QW:0] en_c;
	logic [QW:0] v_c, deg_c;
	logic [QW:0][CORNERS-1:0][RW-1:0] r_c;
	logic [QW:0][CORNERS-1:0][YW-1:0] y_c;
	logic [QW:0][CORNERS-1:0][4*D-1:0] p_c;
	logic [QW:0][CORNERS-1:0][QW-1:0] q_c;
	logic [CORNERS-1:0][4*D-1:0] asq;

	qmsc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .ccw(ccw_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_quad(s_axis_tuser), .in_xy(xy),
		.nx_en(en_c[0]), .v_out(v_c[0]), .deg_out(deg_c[0]),
		.asq_out(asq), .prod_out(p_c[0])
	);

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			r_c[0][i] = RW'(asq[i]) << (2 * FRAC_BITS);
			y_c[0][i] = '0;
			q_c[0][i] = '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_root
		qmsc_root_stage #(
			.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - k)
		) u_stage (
			.clk(clk), .arst_n(arst_n),
			.v_in(v_c[k]), .deg_in(deg_c[k]),
			.r_in(r_c[k]), .y_in(y_c[k]), .p_in(p_c[k]), .q_in(q_c[k]),
			.nx_en(en_c[k+1]), .en(en_c[k]),
			.v_out(v_c[k+1]), .deg_out(deg_c[k+1]),
			.r_out(r_c[k+1]), .y_out(y_c[k+1]), .p_out(p_c[k+1]), .q_out(q_c[k+1])
		);
	end

	logic [QW-1:0] min_sine;

	qmsc_min_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk(clk), .arst_n(arst_n),
		.v_in(v_c[QW]), .deg_in(deg_c[QW]), .q_in(q_c[QW]),
		.en(en_c[QW]), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.min_sine(min_sine), .degenerate(m_axis_tuser)
	);

	assign m_axis_tdata = OW'(min_sine);

endmodule

@@ dv/quad_min_sin_corner_tb.sv @@
// Self-checking testbench for the quad minimum corner sine block.
module quad_min_sin_corner_tb;
	import qmsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic quad;
		logic [127:0] coords;
	} cell_t;

	typedef struct {
		logic [16:0] sine;
		logic degen;
	} quality_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;   // x0, y0, x1, y1, x2, y2, x3, y3
	logic s_axis_tuser = 1'b0;         // is_quad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // min_sine, zero fill
	logic m_axis_tuser;                // degenerate

	cell_t pending_cells[$];
	quality_t expected_quality[$];
	logic order_ccw = 1'b1;
	logic stalls_on = 1'b1;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;

	quad_min_sin_corner u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	function automatic quality_t corner_quality(cell_t c, logic ccw);
		quality_t r;
		logic signed [15:0] raw;
		logic signed [39:0] px[4], py[4], dx[4], dy[4], area[4], len[4];
		logic [159:0] prod, rhs, t;
		logic [16:0] q, tq;
		int src, pv;
		r.sine = '0;
		r.degen = 1'b1;
		if (!c.quad) return r;
		for (int i = 0; i < 4; i++) begin
			src = ccw ? i : 3 - i;
			raw = c.coords[src*32 +: 16];
			px[i] = raw;
			raw = c.coords[src*32 + 16 +: 16];
			py[i] = raw;
		end
		for (int i = 0; i < 4; i++) begin
			dx[i] = px[i] - px[(i + 1) % 4];
			dy[i] = py[i] - py[(i + 1) % 4];
			len[i] = dx[i] * dx[i] + dy[i] * dy[i];
		end
		for (int i = 0; i < 4; i++) begin
			pv = (i + 3) % 4;
			area[i] = dx[pv] * dy[i] - dx[i] * dy[pv];
			if (area[i] <= 0) return r;
		end
		r.sine = 17'h10000;
		r.degen = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pv = (i + 3) % 4;
			prod = {120'd0, len[pv]} * {120'd0, len[i]};
			rhs = ({120'd0, area[i]} * {120'd0, area[i]}) << 32;
			q = '0;
			// Bit-serial square root: keep each bit while q*q*La*Lb stays in bounds.
			for (int b = 16; b >= 0; b--) begin
				tq = q | (17'd1 << b);
				t = {143'd0, tq} * {143'd0, tq} * prod;
				if (t <= rhs) q = tq;
			end
			if (q < r.sine) r.sine = q;
		end
		return r;
	endfunction

	function automatic cell_t make_cell(logic quad, int xs[4], int ys[4]);
		cell_t c;
		c.quad = quad;
		for (int i = 0; i < 4; i++) begin
			c.coords[i*32 +: 16] = 16'(xs[i]);
			c.coords[i*32 + 16 +: 16] = 16'(ys[i]);
		end
		return c;
	endfunction

	// Mostly convex cells, usually wound to match the current order, with random size and place.
	function automatic cell_t random_cell(logic ccw);
		int xs[4], ys[4], tx[4], ty[4], cx, cy, sh, kind;
		cell_t c;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			c.quad = 1'($urandom_range(0, 1));
			c.coords = {$urandom, $urandom, $urandom, $urandom};
			return c;
		end
		sh = $urandom_range(0, 14);
		cx = $signed($urandom_range(0, 32767)) - 16384;
		cy = $signed($urandom_range(0, 32767)) - 16384;
		xs[0] = cx - $urandom_range(1, 16383 >> sh) - 1;
		ys[0] = cy - $urandom_range(0, 16383 >> sh);
		xs[1] = cx + $urandom_range(0, 16383 >> sh);
		ys[1] = cy - $urandom_range(1, 16383 >> sh) - 1;
		xs[2] = cx + $urandom_range(1, 16383 >> sh) + 1;
		ys[2] = cy + $urandom_range(0, 16383 >> sh);
		xs[3] = cx - $urandom_range(0, 16383 >> sh);
		ys[3] = cy + $urandom_range(1, 16383 >> sh) + 1;
		// Either wind to match the register or deliberately against it.
		for (int i = 0; i < 4; i++) begin
			tx[i] = (ccw ^ (kind == 1)) ? xs[i] : xs[3 - i];
			ty[i] = (ccw ^ (kind == 1)) ? ys[i] : ys[3 - i];
		end
		return make_cell(kind != 2, tx, ty);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 16);
				s_axis_tvalid <= 1'b0;
			end else if (pending_cells.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= pending_cells[0].quad;
				s_axis_tdata <= pending_cells[0].coords;
				void'(pending_cells.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_quality.push_back(corner_quality('{s_axis_tuser, s_axis_tdata}, order_ccw));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_quality.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: sine %h degen %b", m_axis_tdata, m_axis_tuser);
			end else begin
				if (m_axis_tdata !== {7'd0, expected_quality[0].sine} ||
						m_axis_tuser !== expected_quality[0].degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected sine %h degen %b, got sine %h degen %b",
							expected_quality[0].sine, expected_quality[0].degen,
							m_axis_tdata, m_axis_tuser);
				end
				void'(expected_quality.pop_front());
			end
		end
	end

	task automatic drain();
		while (pending_cells.size() > 0 || s_axis_tvalid || expected_quality.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_order(logic ccw);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ccw;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_ccw = ccw;
	endtask

	task automatic directed_cells();
		int xs[4], ys[4];
		xs = '{0, 100, 100, 0}; ys = '{0, 0, 100, 100};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		pending_cells.push_back(make_cell(1'b0, xs, ys));
		xs = '{-32768, 32767, 32767, -32768}; ys = '{-32768, -32768, 32767, 32767};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		xs = '{-32768, -32768, 32767, 32767}; ys = '{-32768, 32767, 32767, -32768};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		xs = '{0, 0, 0, 0}; ys = '{0, 0, 0, 0};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		// Collinear corner.
		xs = '{0, 50, 100, 0}; ys = '{0, 0, 0, 100};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		// Self-crossing bow tie.
		xs = '{0, 100, 0, 100}; ys = '{0, 100, 100, 0};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		// Very thin kite: sine a tiny fraction of one, yet not degenerate.
		xs = '{-32768, 0, 32767, 0}; ys = '{0, -1, 0, 1};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		xs = '{-32768, 32767, 32767, -32768}; ys = '{-1, -1, 0, 0};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		xs = '{0, 3, 1, -2}; ys = '{0, 1, 4, 3};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
		xs = '{-1, -1, -1, -1}; ys = '{32767, -32768, 32767, -32768};
		pending_cells.push_back(make_cell(1'b1, xs, ys));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		directed_cells();
		drain();
		write_order(1'b0);
		directed_cells();
		for (int i = 0; i < 600; i++) pending_cells.push_back(random_cell(order_ccw));
		drain();
		write_order(1'b1);
		for (int i = 0; i < 700; i++) pending_cells.push_back(random_cell(order_ccw));
		drain();
		write_order(1'b0);
		stalls_on = 1'b0;
		for (int i = 0; i < 700; i++) pending_cells.push_back(random_cell(order_ccw));
		drain();
		if (mismatches == 0 && expected_quality.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
